// ===== design/utl_pkg.sv =====
// shared types, constants and calendar helpers for the utc to local time converter
// no dependencies; imported by every module of the block

package utl_pkg;

	// configuration register indexes
	localparam logic [0:0] REG_TZ_OFFSET  = 1'b0;
	localparam logic [0:0] REG_DST_ENABLE = 1'b1;

	// configuration reset values
	localparam logic signed [10:0] TZ_OFFSET_RESET  = -11'sd300;
	localparam logic               DST_ENABLE_RESET = 1'b1;

	localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
	localparam logic [11:0] MIN_PER_DAY     = 12'd1440;
	localparam logic [10:0] MIN_PER_HOUR    = 11'd60;

	// march-based year index k counts from 1999-03-01; first year past the skipped 2100 leap day
	localparam logic [7:0] CENTURY_SKIP_K = 8'd101;

	// year estimate: floor(day * K0_MULT / 2^22) is the year index or one below it
	localparam logic [13:0] K0_MULT = 14'd11483;

	// changeover points, day of march-based year and minute of day
	localparam logic [8:0]  SPRING_DOY = 9'd13;   // march 14
	localparam logic [8:0]  FALL_DOY   = 9'd251;  // november 7
	localparam logic [10:0] SPRING_MIN = 11'd120; // 02:00 standard
	localparam logic [10:0] FALL_MIN   = 11'd60;  // 01:00 standard

	// one utc fix as it arrives
	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] date;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} utc_fix_t;

	// local standard day number and minute of day
	typedef struct packed {
		logic [15:0] lday;
		logic [10:0] mday;
		logic [5:0]  sec;
	} day_pos_t;

	// march-based year index and day within it
	typedef struct packed {
		logic [7:0]  myear;
		logic [8:0]  doy;
		logic [10:0] mday;
		logic [5:0]  sec;
	} year_pos_t;

	// position after the daylight saving adjustment
	typedef struct packed {
		logic [7:0]  myear;
		logic [8:0]  doy;
		logic [2:0]  wys;
		logic [10:0] mday;
		logic [5:0]  sec;
		logic        dst;
	} local_pos_t;

	// finished local time
	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] date;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic [2:0] weekday;
		logic       dst;
	} local_time_t;

	// first day of each month within a march-based year, march is index 0
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] d;
		case (mp)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd61;
			4'd3:    d = 9'd92;
			4'd4:    d = 9'd122;
			4'd5:    d = 9'd153;
			4'd6:    d = 9'd184;
			4'd7:    d = 9'd214;
			4'd8:    d = 9'd245;
			4'd9:    d = 9'd275;
			4'd10:   d = 9'd306;
			4'd11:   d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// day number of march 1 of year index k, counted from 1999-03-01
	function automatic logic [15:0] year_start(input logic [7:0] k);
		logic [8:0]  ksum;
		logic [15:0] days;
		ksum = {1'b0, k} + 9'd3;
		days = {8'd0, k} * 16'd365 + {9'd0, ksum[8:2]} - {15'd0, (k >= CENTURY_SKIP_K)};
		return days;
	endfunction

	// remainder by seven through a reciprocal, exact for any 9-bit value
	function automatic logic [2:0] mod7(input logic [8:0] v);
		logic [17:0] p;
		logic [8:0]  r;
		p = {9'd0, v} * 18'd293;
		r = v - {2'b00, p[17:11]} * 9'd7;
		return r[2:0];
	endfunction

endpackage

// ===== design/utl_front.sv =====
// front stage: folds the fix and zone offset into a local standard day number
// and minute of day; depends on utl_pkg

module utl_front import utl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_s1,
	input  utc_fix_t         fix_s1,
	input  logic signed [10:0] zone,
	output logic             vld_s2,
	output day_pos_t         day_s2
);

	logic              m_zero;
	logic              m_over;
	logic              m_early;
	logic [3:0]        mn;
	logic [3:0]        mp;
	logic [8:0]        yp_w;
	logic              sec_carry;
	logic [5:0]        sec_n;
	logic [10:0]       umin;
	logic signed [12:0] mtot;
	logic signed [12:0] mday_w;
	logic [1:0]        c1;
	day_pos_t          day_d;

	// month normalization and march-based year index
	always_comb begin
		m_zero  = fix_s1.month == 4'd0;
		m_over  = fix_s1.month > MONTHS_PER_YEAR;
		if (m_zero) begin
			mn = MONTHS_PER_YEAR;
		end else if (m_over) begin
			mn = fix_s1.month - MONTHS_PER_YEAR;
		end else begin
			mn = fix_s1.month;
		end
		m_early = mn <= 4'd2;
		yp_w = {2'b00, fix_s1.year} + 9'd1 + {8'd0, m_over} - {8'd0, m_zero}
			- {8'd0, m_early};
		mp = m_early ? mn + 4'd9 : mn - 4'd3;
	end

	// minute of day with zone offset, and the day carry it causes
	always_comb begin
		sec_carry = fix_s1.seconds >= 6'd60;
		sec_n     = sec_carry ? fix_s1.seconds - 6'd60 : fix_s1.seconds;
		umin      = {6'd0, fix_s1.hours} * MIN_PER_HOUR + {5'd0, fix_s1.minutes}
			+ {10'd0, sec_carry};
		mtot      = $signed({2'b00, umin}) + $signed({{2{zone[10]}}, zone});
		if (mtot < 13'sd0) begin
			c1     = 2'd0;
			mday_w = mtot + 13'sd1440;
		end else if (mtot < 13'sd1440) begin
			c1     = 2'd1;
			mday_w = mtot;
		end else if (mtot < 13'sd2880) begin
			c1     = 2'd2;
			mday_w = mtot - 13'sd1440;
		end else begin
			c1     = 2'd3;
			mday_w = mtot - 13'sd2880;
		end
	end

	// day number: date is one-based and c1 carries an offset of one
	always_comb begin
		day_d.lday = year_start(yp_w[7:0]) + {7'd0, month_start(mp)}
			+ {11'd0, fix_s1.date} + {14'd0, c1} - 16'd2;
		day_d.mday = mday_w[10:0];
		day_d.sec  = sec_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		day_s2 <= day_d;
	end

endmodule

// ===== design/utl_locate.sv =====
// year locate: estimates the march-based year of a day number by reciprocal
// and corrects it against the year start; depends on utl_pkg

module utl_locate import utl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      vld_s2,
	input  day_pos_t  day_s2,
	output logic      vld_s4,
	output year_pos_t yr_s4
);

	logic [29:0] prod;
	logic        vld_s3;
	day_pos_t    day_s3;
	logic [7:0]  k0_s3;
	logic [7:0]  k1;
	logic [15:0] ys0;
	logic [15:0] ys1;
	logic        past;
	logic [15:0] doy_w;
	year_pos_t   yr_d;

	// year estimate, exact or one low
	assign prod = {14'd0, day_s2.lday} * {16'd0, K0_MULT};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		day_s3 <= day_s2;
		k0_s3  <= prod[29:22];
	end

	// correction against the start of the next year
	always_comb begin
		k1         = k0_s3 + 8'd1;
		ys0        = year_start(k0_s3);
		ys1        = year_start(k1);
		past       = day_s3.lday >= ys1;
		doy_w      = day_s3.lday - (past ? ys1 : ys0);
		yr_d.myear = past ? k1 : k0_s3;
		yr_d.doy   = doy_w[8:0];
		yr_d.mday  = day_s3.mday;
		yr_d.sec   = day_s3.sec;
	end

	always_ff @(posedge clk) begin
		yr_s4 <= yr_d;
	end

endmodule

// ===== design/utl_dst.sv =====
// daylight saving stage: finds the changeover sundays of the year, tests the
// window and adds the hour; depends on utl_pkg

module utl_dst import utl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       dst_en,
	input  logic       vld_s4,
	input  year_pos_t  yr_s4,
	output logic       vld_s5,
	output local_pos_t loc_s5
);

	logic [8:0]  ksum;
	logic [8:0]  wsum;
	logic [2:0]  wys;
	logic [3:0]  w6_w;
	logic [2:0]  w6;
	logic [8:0]  sdoy;
	logic [8:0]  fdoy;
	logic        after_spring;
	logic        before_fall;
	logic        dst;
	logic [11:0] msum;
	logic        wrap;
	logic [11:0] mday_w;
	local_pos_t  loc_d;

	// weekday of march 1, day 0 (1999-03-01) is a monday
	always_comb begin
		ksum = {1'b0, yr_s4.myear} + 9'd3;
		wsum = {1'b0, yr_s4.myear} + {2'b00, ksum[8:2]}
			- {8'd0, (yr_s4.myear >= CENTURY_SKIP_K)} + 9'd1;
		wys  = mod7(wsum);
	end

	// march 14 and november 7 share a weekday; step back to sunday
	always_comb begin
		w6_w = {1'b0, wys} + 4'd6;
		w6   = (w6_w >= 4'd7) ? 3'(w6_w - 4'd7) : w6_w[2:0];
		sdoy = SPRING_DOY - {6'd0, w6};
		fdoy = FALL_DOY - {6'd0, w6};
	end

	// window test on standard time, then add the hour
	always_comb begin
		after_spring = (yr_s4.doy > sdoy)
			|| ((yr_s4.doy == sdoy) && (yr_s4.mday >= SPRING_MIN));
		before_fall  = (yr_s4.doy < fdoy)
			|| ((yr_s4.doy == fdoy) && (yr_s4.mday < FALL_MIN));
		dst          = dst_en & after_spring & before_fall;
		msum         = {1'b0, yr_s4.mday} + (dst ? {1'b0, MIN_PER_HOUR} : 12'd0);
		wrap         = msum >= MIN_PER_DAY;
		mday_w       = wrap ? msum - MIN_PER_DAY : msum;
		// the window ends in november, so the extra day never leaves the year
		loc_d.myear  = yr_s4.myear;
		loc_d.doy    = yr_s4.doy + {8'd0, wrap};
		loc_d.wys    = wys;
		loc_d.mday   = mday_w[10:0];
		loc_d.sec    = yr_s4.sec;
		loc_d.dst    = dst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		loc_s5 <= loc_d;
	end

endmodule

// ===== design/utl_civil.sv =====
// civil stage: splits day of year into month and date, minute of day into
// hours and minutes, and forms weekday and year; depends on utl_pkg

module utl_civil import utl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vld_s5,
	input  local_pos_t  loc_s5,
	output logic        done_s6,
	output local_time_t res_s6
);

	logic [10:0] mpv;
	logic [23:0] mprod;
	logic [3:0]  mp;
	logic        jan_feb;
	logic [8:0]  date_w;
	logic [8:0]  yt;
	logic [8:0]  year_w;
	logic [21:0] hprod;
	logic [4:0]  hr;
	logic [10:0] min_w;
	logic [2:0]  wd0;
	local_time_t res_d;

	// month index (5*doy+2)/153 by reciprocal
	always_comb begin
		mpv     = {2'b00, loc_s5.doy} * 11'd5 + 11'd2;
		mprod   = {13'd0, mpv} * 24'd6854;
		mp      = mprod[23:20];
		date_w  = loc_s5.doy - month_start(mp) + 9'd1;
		jan_feb = mp >= 4'd10;
	end

	// year within century, march-based year 0 is 1999
	always_comb begin
		yt = {1'b0, loc_s5.myear} + {8'd0, jan_feb} + 9'd99;
		if (yt >= 9'd200) begin
			year_w = yt - 9'd200;
		end else if (yt >= 9'd100) begin
			year_w = yt - 9'd100;
		end else begin
			year_w = yt;
		end
	end

	// hours by reciprocal of sixty, weekday from march 1
	always_comb begin
		hprod = {11'd0, loc_s5.mday} * 22'd1093;
		hr    = hprod[20:16];
		min_w = loc_s5.mday - {6'd0, hr} * MIN_PER_HOUR;
		wd0   = mod7({6'd0, loc_s5.wys} + loc_s5.doy);
	end

	always_comb begin
		res_d.year    = year_w[6:0];
		res_d.month   = jan_feb ? mp - 4'd9 : mp + 4'd3;
		res_d.date    = date_w[4:0];
		res_d.hours   = hr;
		res_d.minutes = min_w[5:0];
		res_d.seconds = loc_s5.sec;
		res_d.weekday = wd0 + 3'd1;
		res_d.dst     = loc_s5.dst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s6 <= 1'b0;
		end else begin
			done_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		res_s6 <= res_d;
	end

endmodule

// ===== design/utc_to_local_time_with_dst.sv =====
// utc to local time converter with the us daylight saving rule
// a fix taken at a clock edge gives its done strobe once it has passed the input register and stages s2 to s6
// throughput: one fix per cycle, set by the six-stage pipeline; busy stays low
// done is a one-cycle strobe; the receiver cannot stall, so nothing backs up
// reset clears the pipeline valid flags and loads offset -300 minutes, dst enabled
// depends on utl_pkg, utl_front, utl_locate, utl_dst and utl_civil

module utc_to_local_time_with_dst import utl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [10:0] cfg_wdata,
	input  logic [6:0]  utc_year,
	input  logic [3:0]  utc_month,
	input  logic [4:0]  utc_date,
	input  logic [4:0]  utc_hours,
	input  logic [5:0]  utc_minutes,
	input  logic [5:0]  utc_seconds,
	output logic        done,
	output logic [6:0]  local_year,
	output logic [3:0]  local_month,
	output logic [4:0]  local_date,
	output logic [4:0]  local_hours,
	output logic [5:0]  local_minutes,
	output logic [5:0]  local_seconds,
	output logic [2:0]  local_weekday,
	output logic        dst_in_effect
);

	logic signed [10:0] zone_q;
	logic               dst_en_q;
	logic               accept;
	logic               vld_s1;
	utc_fix_t           fix_s1;
	logic               vld_s2;
	day_pos_t           day_s2;
	logic               vld_s4;
	year_pos_t          yr_s4;
	logic               vld_s5;
	local_pos_t         loc_s5;
	local_time_t        res_s6;

	// the pipeline takes a transaction every cycle
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q   <= TZ_OFFSET_RESET;
			dst_en_q <= DST_ENABLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TZ_OFFSET:  zone_q   <= $signed(cfg_wdata);
				REG_DST_ENABLE: dst_en_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fix_s1.year    <= utc_year;
			fix_s1.month   <= utc_month;
			fix_s1.date    <= utc_date;
			fix_s1.hours   <= utc_hours;
			fix_s1.minutes <= utc_minutes;
			fix_s1.seconds <= utc_seconds;
		end
	end

	utl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s1 (vld_s1),
		.fix_s1 (fix_s1),
		.zone   (zone_q),
		.vld_s2 (vld_s2),
		.day_s2 (day_s2)
	);

	utl_locate u_locate (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s2 (vld_s2),
		.day_s2 (day_s2),
		.vld_s4 (vld_s4),
		.yr_s4  (yr_s4)
	);

	utl_dst u_dst (
		.clk    (clk),
		.arst_n (arst_n),
		.dst_en (dst_en_q),
		.vld_s4 (vld_s4),
		.yr_s4  (yr_s4),
		.vld_s5 (vld_s5),
		.loc_s5 (loc_s5)
	);

	utl_civil u_civil (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s5  (vld_s5),
		.loc_s5  (loc_s5),
		.done_s6 (done),
		.res_s6  (res_s6)
	);

	// result ports
	assign local_year    = res_s6.year;
	assign local_month   = res_s6.month;
	assign local_date    = res_s6.date;
	assign local_hours   = res_s6.hours;
	assign local_minutes = res_s6.minutes;
	assign local_seconds = res_s6.seconds;
	assign local_weekday = res_s6.weekday;
	assign dst_in_effect = res_s6.dst;

endmodule

// ===== verif/utc_to_local_time_with_dst_checker.sv =====
// checker for the utc to local time converter: predicts each local time and compares
// depends on utl_pkg for the fix and local time structs and the register indexes

module utc_to_local_time_with_dst_checker import utl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [10:0] cfg_wdata,
	input  utc_fix_t    fix,
	input  logic        done,
	input  local_time_t shown,
	output int          failures,
	output int          pending
);

	localparam longint SEC_PER_DAY  = 86400;
	localparam longint SEC_PER_HOUR = 3600;
	localparam longint SEC_PER_MIN  = 60;
	localparam longint BASE_YEAR    = 2000;
	// us rule: sunday on or before march 14 at 02:00, sunday on or before november 7 at 01:00
	localparam longint SPRING_MONTH  = 3;
	localparam longint SPRING_LATEST = 14;
	localparam longint SPRING_HOUR   = 2;
	localparam longint FALL_MONTH    = 11;
	localparam longint FALL_LATEST   = 7;
	localparam longint FALL_HOUR     = 1;

	logic signed [10:0] tz_offset;
	logic               dst_on;
	local_time_t        expected_local [$];

	// days since 1970-01-01, proleptic gregorian, months past february are linear
	function automatic longint days_since_epoch(longint y, longint m, longint d);
		longint era, yoe, doy, doe;
		if (m <= 2) begin
			y = y - 1;
		end
		era = y / 400;
		yoe = y - era * 400;
		doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	// calendar date from a non-negative day count
	function automatic void calendar_of(input longint z, output longint y, output longint m,
			output longint d);
		longint era, doe, yoe, doy, mp;
		z = z + 719468;
		era = z / 146097;
		doe = z - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		d = doy - (153 * mp + 2) / 5 + 1;
		m = mp < 10 ? mp + 3 : mp - 9;
		y = yoe + era * 400 + (m <= 2 ? 1 : 0);
	endfunction

	// second count of the sunday on or before the latest date, at the given hour
	function automatic longint changeover_sec(longint y, longint m, longint latest, longint hour);
		longint days;
		days = days_since_epoch(y, m, latest);
		days = days - (days + 4) % 7;
		return days * SEC_PER_DAY + hour * SEC_PER_HOUR;
	endfunction

	// local date and time for one utc fix under the given zone and dst setting
	function automatic local_time_t local_time_of(utc_fix_t f, logic signed [10:0] offset,
			logic dst_en);
		longint y, m, off, secs, days, rem, ly, lm, ld, spring, fall;
		local_time_t t;
		y = BASE_YEAR + longint'(f.year);
		m = longint'(f.month);
		off = offset;
		// month zero borrows from the previous year, months past twelve carry
		if (m == 0) begin
			m = 12;
			y = y - 1;
		end else if (m > 12) begin
			m = m - 12;
			y = y + 1;
		end
		secs = days_since_epoch(y, m, longint'(f.date)) * SEC_PER_DAY
			+ longint'(f.hours) * SEC_PER_HOUR + longint'(f.minutes) * SEC_PER_MIN
			+ longint'(f.seconds) + off * SEC_PER_MIN;
		t.dst = 1'b0;
		// dst window taken in the local standard year
		if (dst_en) begin
			calendar_of(secs / SEC_PER_DAY, ly, lm, ld);
			spring = changeover_sec(ly, SPRING_MONTH, SPRING_LATEST, SPRING_HOUR);
			fall = changeover_sec(ly, FALL_MONTH, FALL_LATEST, FALL_HOUR);
			if (spring <= secs && secs < fall) begin
				secs = secs + SEC_PER_HOUR;
				t.dst = 1'b1;
			end
		end
		days = secs / SEC_PER_DAY;
		rem = secs - days * SEC_PER_DAY;
		calendar_of(days, ly, lm, ld);
		t.year = 7'(ly % 100);
		t.month = 4'(lm);
		t.date = 5'(ld);
		t.hours = 5'(rem / SEC_PER_HOUR);
		t.minutes = 6'((rem % SEC_PER_HOUR) / SEC_PER_MIN);
		t.seconds = 6'(rem % SEC_PER_MIN);
		t.weekday = 3'((days + 4) % 7 + 1);
		return t;
	endfunction

	function automatic int field_bad(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// track configuration, queue predictions, compare each result transaction
	always @(posedge clk or negedge arst_n) begin
		local_time_t want;
		int bad;
		if (!arst_n) begin
			tz_offset <= TZ_OFFSET_RESET;
			dst_on <= DST_ENABLE_RESET;
			expected_local.delete();
			pending <= 0;
			failures <= 0;
		end else begin
			bad = 0;
			if (cfg_we) begin
				case (cfg_index)
					REG_TZ_OFFSET:  tz_offset <= cfg_wdata;
					REG_DST_ENABLE: dst_on <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (done) begin
				if (expected_local.size() == 0) begin
					$display("%0t: result with no transaction outstanding", $time);
					bad = 1;
				end else begin
					want = expected_local.pop_front();
					bad += field_bad("local_year", want.year, shown.year);
					bad += field_bad("local_month", want.month, shown.month);
					bad += field_bad("local_date", want.date, shown.date);
					bad += field_bad("local_hours", want.hours, shown.hours);
					bad += field_bad("local_minutes", want.minutes, shown.minutes);
					bad += field_bad("local_seconds", want.seconds, shown.seconds);
					bad += field_bad("local_weekday", want.weekday, shown.weekday);
					bad += field_bad("dst_in_effect", want.dst, shown.dst);
				end
			end
			if (start && !busy) begin
				expected_local.push_back(local_time_of(fix, tz_offset, dst_on));
			end
			pending <= expected_local.size();
			failures <= failures + bad;
		end
	end

endmodule

// ===== verif/utc_to_local_time_with_dst_test.sv =====
// testbench top for the utc to local time converter: clock, reset, stimulus and verdict
// depends on utl_pkg, the converter rtl and utc_to_local_time_with_dst_checker

module utc_to_local_time_with_dst_test import utl_pkg::*; ();

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 137;
	localparam int SETTLE_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT  = 1000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_TZ_OFFSET;
	logic [10:0] cfg_wdata = '0;
	logic [6:0]  utc_year = '0;
	logic [3:0]  utc_month = '0;
	logic [4:0]  utc_date = '0;
	logic [4:0]  utc_hours = '0;
	logic [5:0]  utc_minutes = '0;
	logic [5:0]  utc_seconds = '0;
	logic        done;
	logic [6:0]  local_year;
	logic [3:0]  local_month;
	logic [4:0]  local_date;
	logic [4:0]  local_hours;
	logic [5:0]  local_minutes;
	logic [5:0]  local_seconds;
	logic [2:0]  local_weekday;
	logic        dst_in_effect;
	int          failures;
	int          pending;
	int          quiet_cycles = 0;
	logic        calm = 1'b0;

	utc_to_local_time_with_dst dut (.*);

	utc_to_local_time_with_dst_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.fix      ({utc_year, utc_month, utc_date, utc_hours, utc_minutes, utc_seconds}),
		.done     (done),
		.shown    ({local_year, local_month, local_date, local_hours, local_minutes,
			local_seconds, local_weekday, dst_in_effect}),
		.failures (failures),
		.pending  (pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// watchdog on cycles with no transaction in either direction
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// present one fix after a random gap and hold it until accepted
	task automatic issue_fix(utc_fix_t f);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		utc_year <= f.year;
		utc_month <= f.month;
		utc_date <= f.date;
		utc_hours <= f.hours;
		utc_minutes <= f.minutes;
		utc_seconds <= f.seconds;
		do @(posedge clk); while (busy);
	endtask

	// stop sending and wait for every outstanding conversion
	task automatic drain_conversions();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers while the pipeline is empty
	task automatic write_zone(logic signed [10:0] offset, logic dst_en);
		cfg_we <= 1'b1;
		cfg_index <= REG_TZ_OFFSET;
		cfg_wdata <= offset;
		@(posedge clk);
		cfg_index <= REG_DST_ENABLE;
		cfg_wdata <= {10'd0, dst_en};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mix of full-width noise, dst changeover weeks, year edges and ordinary dates
	function automatic utc_fix_t random_fix();
		utc_fix_t f;
		int kind;
		kind = $urandom_range(0, 99);
		f.year = 7'($urandom_range(0, 99));
		f.month = 4'($urandom_range(1, 12));
		f.date = 5'($urandom_range(1, 31));
		f.hours = 5'($urandom_range(0, 23));
		f.minutes = 6'($urandom_range(0, 59));
		f.seconds = 6'($urandom_range(0, 59));
		if (kind < 15) begin
			f = utc_fix_t'($urandom);
			f.year = 7'($urandom);
		end else if (kind < 45) begin
			f.month = $urandom_range(0, 1) ? 4'd3 : 4'd11;
			f.date = 5'($urandom_range(1, 15));
			if ($urandom_range(0, 1)) begin
				f.minutes = $urandom_range(0, 1) ? 6'd59 : 6'd0;
				f.seconds = f.minutes;
			end
		end else if (kind < 55) begin
			f.month = $urandom_range(0, 1) ? 4'd12 : 4'd1;
			f.date = (f.month == 4'd12) ? 5'd31 : 5'd1;
			f.year = $urandom_range(0, 3) == 0 ? 7'd99 : f.year;
		end
		return f;
	endfunction

	initial begin
		utc_fix_t corner [$];
		logic signed [10:0] offsets [PHASES];
		logic dst_modes [PHASES];

		offsets = '{11'sd840, -11'sd720, 11'sd1023, 11'h400, 11'sd0, 11'sd0, 11'sd0, -11'sd300};
		dst_modes = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
		offsets[5] = 11'($urandom);
		offsets[6] = 11'($urandom);
		dst_modes[5] = 1'($urandom);

		// month zero, date zero and wrap back to year 99
		corner.push_back('{7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0});
		// every field at its top
		corner.push_back('{7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63});
		// leap days: 2024, 2000, and 2100 which is not a leap year
		corner.push_back('{7'd24, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0});
		corner.push_back('{7'd0, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0});
		corner.push_back('{7'd100, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0});
		// date past month end, month thirteen, time fields past range
		corner.push_back('{7'd23, 4'd2, 5'd31, 5'd12, 6'd0, 6'd0});
		corner.push_back('{7'd23, 4'd13, 5'd5, 5'd12, 6'd0, 6'd0});
		corner.push_back('{7'd23, 4'd6, 5'd15, 5'd30, 6'd63, 6'd63});
		corner.push_back('{7'd0, 4'd0, 5'd31, 5'd0, 6'd0, 6'd0});
		// spring changeover 2024-03-10 at offset -300, the second before it and the changeover itself
		corner.push_back('{7'd24, 4'd3, 5'd10, 5'd6, 6'd59, 6'd59});
		corner.push_back('{7'd24, 4'd3, 5'd10, 5'd7, 6'd0, 6'd0});
		// fall changeover 2024-11-03, the second before it and the changeover itself
		corner.push_back('{7'd24, 4'd11, 5'd3, 5'd5, 6'd59, 6'd59});
		corner.push_back('{7'd24, 4'd11, 5'd3, 5'd6, 6'd0, 6'd0});
		// changeover sundays on the latest allowed dates in 2021
		corner.push_back('{7'd21, 4'd3, 5'd14, 5'd7, 6'd0, 6'd0});
		corner.push_back('{7'd21, 4'd11, 5'd7, 5'd5, 6'd30, 6'd0});
		// century edges and a mid-century date
		corner.push_back('{7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59});
		corner.push_back('{7'd0, 4'd1, 5'd1, 5'd3, 6'd0, 6'd0});
		corner.push_back('{7'd50, 4'd7, 5'd4, 5'd0, 6'd0, 6'd0});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed fixes under the reset zone
		foreach (corner[i]) begin
			issue_fix(corner[i]);
		end
		drain_conversions();

		for (int p = 0; p < PHASES; p++) begin
			write_zone(offsets[p], dst_modes[p]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 32 == 0) begin
					calm = ($urandom_range(0, 2) == 0);
				end
				issue_fix(random_fix());
			end
			drain_conversions();
		end

		if (failures == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== utc_to_local_time_with_dst.f =====
design/utl_pkg.sv
design/utl_front.sv
design/utl_locate.sv
design/utl_dst.sv
design/utl_civil.sv
design/utc_to_local_time_with_dst.sv
verif/utc_to_local_time_with_dst_checker.sv
verif/utc_to_local_time_with_dst_test.sv
